[hw/rtl/smx_pkg.sv]
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and codes for the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

	localparam int PC_W    = 9;
	localparam int DEPTH_W = 9;
	localparam int WORD_W  = 32;
	localparam int DMEM_N  = 256;

	localparam logic [7:0] OP_HALT  = 8'd0;
	localparam logic [7:0] OP_PUSH  = 8'd1;
	localparam logic [7:0] OP_POP   = 8'd2;
	localparam logic [7:0] OP_ADD   = 8'd3;
	localparam logic [7:0] OP_SUB   = 8'd4;
	localparam logic [7:0] OP_MUL   = 8'd5;
	localparam logic [7:0] OP_DIV   = 8'd6;
	localparam logic [7:0] OP_EMIT  = 8'd7;
	localparam logic [7:0] OP_JMP   = 8'd8;
	localparam logic [7:0] OP_JZ    = 8'd9;
	localparam logic [7:0] OP_LOAD  = 8'd10;
	localparam logic [7:0] OP_SAVE  = 8'd11;

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_HALT  = 3'd1;
	localparam logic [2:0] ST_BADOP = 3'd2;
	localparam logic [2:0] ST_UNDER = 3'd3;
	localparam logic [2:0] ST_OVER  = 3'd4;
	localparam logic [2:0] ST_PCEND = 3'd5;

	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] operand;
	} in_item_t;

	typedef struct packed {
		logic [PC_W-1:0]           next_pc;
		logic [2:0]                status;
		logic                      print_valid;
		logic signed [WORD_W-1:0]  print_value;
		logic [DEPTH_W-1:0]        stack_depth;
	} out_item_t;

	typedef struct packed {
		logic take;
		logic rd_a;
		logic cap_b;
		logic cap_a;
		logic div_start;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} stat_t;

endpackage

[hw/rtl/smx_in_if.sv]
// ----------------------------------------------------------------------------
// smx_in_if
// Instruction channel: valid/ready handshake with opcode and operand.
// ----------------------------------------------------------------------------
interface smx_in_if;
	logic              valid;
	logic              ready;
	smx_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/smx_out_if.sv]
// ----------------------------------------------------------------------------
// smx_out_if
// Result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface smx_out_if;
	logic               valid;
	logic               ready;
	smx_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/smx_div.sv]
// ----------------------------------------------------------------------------
// smx_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smx_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quot
);
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] shifted, diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule

[hw/rtl/smx_ctrl.sv]
// ----------------------------------------------------------------------------
// smx_ctrl
// Sequencer: operand fetch, optional divide, execute.
// ----------------------------------------------------------------------------
module smx_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  smx_pkg::stat_t stat,
	output smx_pkg::cmd_t  cmd
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RDA   = 6'b000010,
		S_CAPA  = 6'b000100,
		S_DST   = 6'b001000,
		S_DWAIT = 6'b010000,
		S_EXEC  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_fire) state_d = S_RDA;
			S_RDA:   state_d = S_CAPA;
			S_CAPA:  state_d = stat.need_div ? S_DST : S_EXEC;
			S_DST:   state_d = S_DWAIT;
			S_DWAIT: if (stat.div_done) state_d = S_EXEC;
			S_EXEC:  if (stat.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.take      = (state_q == S_IDLE);
		cmd.rd_a      = (state_q == S_RDA);
		cmd.cap_b     = (state_q == S_RDA);
		cmd.cap_a     = (state_q == S_CAPA);
		cmd.div_start = (state_q == S_DST);
		cmd.exec      = (state_q == S_EXEC) && stat.out_free;
	end
endmodule

[hw/rtl/smx_dpath.sv]
// ----------------------------------------------------------------------------
// smx_dpath
// Operand stack, data memory, machine registers and result register.
// ----------------------------------------------------------------------------
module smx_dpath #(
	parameter int CODE_SIZE   = 256,
	parameter int STACK_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  smx_pkg::cmd_t  cmd,
	output smx_pkg::stat_t stat,
	smx_in_if.sink         in_ch,
	smx_out_if.source      out_ch
);
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int NPW = smx_pkg::PC_W + 1;

	logic [31:0] stack_mem [STACK_DEPTH];
	logic [31:0] dmem [smx_pkg::DMEM_N];
	logic [smx_pkg::DMEM_N-1:0] dval_q;

	logic [7:0]              op_q, arg_q;
	logic [smx_pkg::PC_W-1:0] pc_q;
	logic [SPW-1:0]          sp_q;
	logic [2:0]              stop_q;
	logic [31:0]             b_q, a_q, srd_q, drd_q, ld_q;
	logic                    dv_rd_q;
	logic                    out_valid_q;
	smx_pkg::out_item_t      out_q;

	logic [SPW-1:0] sp_m1, sp_m2;
	logic [AW-1:0]  rd_addr;
	logic           in_fire;
	logic           under, over, neg_q;
	logic           div_done;
	logic [31:0]    quot, ma, mb, qs;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = cmd.take;
	assign sp_m1 = sp_q - SPW'(1);
	assign sp_m2 = sp_q - SPW'(2);
	assign rd_addr = cmd.rd_a ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

	assign under = ((op_q >= smx_pkg::OP_ADD && op_q <= smx_pkg::OP_DIV) && sp_q < SPW'(2))
		|| (op_q == smx_pkg::OP_SAVE && sp_q == '0);
	assign over = (op_q == smx_pkg::OP_PUSH || op_q == smx_pkg::OP_LOAD)
		&& sp_q >= SPW'(STACK_DEPTH);

	assign ma = b_q[31] ? 32'd0 - b_q : b_q;
	assign mb = a_q[31] ? 32'd0 - a_q : a_q;

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mb),
		.divisor  (ma),
		.done     (div_done),
		.quot     (quot)
	);

	assign qs = neg_q ? 32'd0 - quot : quot;

	always_comb begin
		stat.need_div = (stop_q == smx_pkg::ST_RUN) && !under
			&& op_q == smx_pkg::OP_DIV && b_q != '0;
		stat.div_done = div_done;
		stat.out_free = !out_valid_q || out_ch.ready;
	end

	// execute
	logic [NPW-1:0]   npc;
	logic [2:0]       st;
	logic [SPW-1:0]   sp_d;
	logic             pv, swe, dwe;
	logic [AW-1:0]    swa;
	logic [31:0]      swd, val;
	logic [15:0]      sp_w;

	always_comb begin
		npc = NPW'(pc_q) + NPW'(1);
		st  = smx_pkg::ST_RUN;
		sp_d = sp_q;
		pv  = 1'b0;
		val = '0;
		swe = 1'b0;
		swa = sp_q[AW-1:0];
		swd = '0;
		dwe = 1'b0;
		if (stop_q != smx_pkg::ST_RUN) begin
			npc = NPW'(pc_q);
			st  = stop_q;
		end else if (under || over) begin
			npc = NPW'(pc_q);
			st  = under ? smx_pkg::ST_UNDER : smx_pkg::ST_OVER;
		end else begin
			case (op_q)
				smx_pkg::OP_HALT: st = smx_pkg::ST_HALT;
				smx_pkg::OP_PUSH: begin
					swe  = 1'b1;
					swd  = {24'd0, arg_q};
					sp_d = sp_q + SPW'(1);
					npc  = NPW'(pc_q) + NPW'(2);
				end
				smx_pkg::OP_POP: if (sp_q != '0) sp_d = sp_m1;
				smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL: begin
					swe  = 1'b1;
					swa  = sp_m2[AW-1:0];
					sp_d = sp_m1;
					if (op_q == smx_pkg::OP_ADD) swd = a_q + b_q;
					else if (op_q == smx_pkg::OP_SUB) swd = a_q - b_q;
					else swd = a_q * b_q;
				end
				smx_pkg::OP_DIV: begin
					swa = sp_m2[AW-1:0];
					swd = qs;
					if (b_q != '0) begin
						swe  = 1'b1;
						sp_d = sp_m1;
					end else begin
						sp_d = sp_m2;
					end
				end
				smx_pkg::OP_EMIT: if (sp_q != '0) begin
					pv  = 1'b1;
					val = b_q;
				end
				smx_pkg::OP_JMP: npc = NPW'(arg_q);
				smx_pkg::OP_JZ: begin
					npc = NPW'(pc_q) + NPW'(2);
					if (sp_q != '0) begin
						sp_d = sp_m1;
						if (b_q == '0) npc = NPW'(arg_q);
					end
				end
				smx_pkg::OP_LOAD: begin
					swe  = 1'b1;
					swd  = ld_q;
					sp_d = sp_q + SPW'(1);
					npc  = NPW'(pc_q) + NPW'(2);
				end
				smx_pkg::OP_SAVE: begin
					dwe  = 1'b1;
					sp_d = sp_m1;
					npc  = NPW'(pc_q) + NPW'(2);
				end
				default: st = smx_pkg::ST_BADOP;
			endcase
			if (st == smx_pkg::ST_RUN && npc >= NPW'(CODE_SIZE)) begin
				st  = smx_pkg::ST_PCEND;
				npc = NPW'(CODE_SIZE);
			end
			if (npc > NPW'(CODE_SIZE)) npc = NPW'(CODE_SIZE);
		end
		sp_w = 16'(sp_d);
	end

	always_ff @(posedge clk) begin
		srd_q <= stack_mem[rd_addr];
		if (cmd.exec && swe) stack_mem[swa] <= swd;
	end

	always_ff @(posedge clk) begin
		drd_q <= dmem[in_ch.data.operand];
		if (cmd.exec && dwe) dmem[arg_q] <= b_q;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= in_ch.data.opcode;
			arg_q <= in_ch.data.operand;
		end
		if (cmd.cap_b) begin
			b_q  <= srd_q;
			ld_q <= dv_rd_q ? drd_q : 32'd0;
		end
		if (cmd.cap_a) a_q <= srd_q;
		if (cmd.div_start) neg_q <= a_q[31] ^ b_q[31];
		if (cmd.exec) begin
			out_q.next_pc     <= npc[smx_pkg::PC_W-1:0];
			out_q.status      <= st;
			out_q.print_valid <= pv;
			out_q.print_value <= val;
			out_q.stack_depth <= sp_w[smx_pkg::DEPTH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			sp_q        <= '0;
			stop_q      <= smx_pkg::ST_RUN;
			dval_q      <= '0;
			dv_rd_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			dv_rd_q <= dval_q[in_ch.data.operand];
			if (cmd.exec) begin
				pc_q   <= npc[smx_pkg::PC_W-1:0];
				sp_q   <= sp_d;
				stop_q <= st;
				if (dwe) dval_q[arg_q] <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
endmodule

[hw/rtl/stack_machine_executor_unit.sv]
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// Bytecode executor on a 32-bit operand stack and a 256-word data memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one instruction item (opcode, operand) at a time; the caller
//          fetches it from the code store at the last reported next_pc.
//   out_ch gives one result item per instruction: next_pc, status, print
//          flag and value, stack depth.
//   An item goes from accept to result register in the steps accept, two
//   stack reads through the single stack read port, and execute. A divide
//   with a nonzero divisor adds a start and a wait on the bit-serial divider.
//   The next item is accepted in the cycle after the result is loaded; the
//   result register holds the result while the receiver stalls, and execute
//   waits only if a previous result is still not taken.
//   Reset clears pc, depth, stop code and the data memory valid bits at once;
//   no clearing pass. A nonzero status stops execution: later items return
//   the held pc and stop code until reset.
// ----------------------------------------------------------------------------
module stack_machine_executor_unit #(
	parameter int CODE_SIZE   = 256,
	parameter int STACK_DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	smx_in_if.sink    in_ch,
	smx_out_if.source out_ch
);
	smx_pkg::cmd_t  cmd;
	smx_pkg::stat_t stat;

	smx_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_ch.valid && in_ch.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	smx_dpath #(
		.CODE_SIZE   (CODE_SIZE),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	a_run_pc: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.status == smx_pkg::ST_RUN
		|-> out_ch.data.next_pc < 9'(CODE_SIZE))
		else $error("running pc out of range");

	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.print_valid
		|-> out_ch.data.status == smx_pkg::ST_RUN
			|| out_ch.data.status == smx_pkg::ST_PCEND)
		else $error("print with stop status");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("second item taken while busy");
endmodule
